[rtl/pva_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types, constants and tables of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

	localparam int NUM_VOICES  = 16;
	localparam int ROOT_KEY    = 60;
	localparam int MAX_RESULTS = 16;
	localparam int NRES        = (NUM_VOICES < MAX_RESULTS) ? NUM_VOICES : MAX_RESULTS;
	localparam int VW          = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int KW          = (NRES > 1) ? $clog2(NRES) : 1;
	localparam int KEY_BIAS    = 132 - ROOT_KEY;

	localparam logic [16:0] FADE_ONE = 17'd65536;
	localparam logic [39:0] POS_MAX  = 40'hFF_FFFF_FFFF;
	localparam logic [23:0] RATE_MAX = 24'hFF_FFFF;

	localparam logic [2:0] FN_NOTE_ON  = 3'd0;
	localparam logic [2:0] FN_NOTE_OFF = 3'd1;
	localparam logic [2:0] FN_ALL_OFF  = 3'd2;
	localparam logic [2:0] FN_TICK     = 3'd3;
	localparam logic [2:0] FN_RESET    = 3'd4;

	localparam logic [2:0] REG_RELEASE_STEP  = 3'd0;
	localparam logic [2:0] REG_STEAL_STEP    = 3'd1;
	localparam logic [2:0] REG_DEVICE_RATIO  = 3'd2;
	localparam logic [2:0] REG_SAMPLE_FRAMES = 3'd3;
	localparam logic [2:0] REG_CLIP_MODE     = 3'd4;
	localparam logic [2:0] REG_CLIP_START    = 3'd5;
	localparam logic [2:0] REG_CLIP_LENGTH   = 3'd6;
	localparam logic [2:0] REG_CLIP_RATE     = 3'd7;

	typedef struct packed {
		logic [2:0]  func;
		logic [6:0]  note;
		logic [15:0] velocity;
	} in_t;

	typedef struct packed {
		logic [5:0]  slot;
		logic        sounding;
		logic [39:0] read_position;
		logic [16:0] amplitude;
		logic        stolen;
		logic [6:0]  active_count;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [6:0]  key;
		logic [15:0] gain;
		logic [39:0] pos;
		logic [23:0] rate;
		logic [16:0] fade;
		logic [16:0] fstep;
		logic [6:0]  pkey;
		logic [15:0] pgain;
		logic [31:0] age;
		logic [23:0] len;
	} voice_ent_t;

	typedef struct packed {
		logic        snd;
		logic [39:0] pos;
		logic [16:0] amp;
	} res_ent_t;

	localparam int ENT_W = $bits(voice_ent_t);
	localparam int RES_W = $bits(res_ent_t);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SWEEP, ST_DRAIN, ST_RESP, ST_EMIT
	} st_t;

	typedef enum logic [2:0] {
		OP_ON, OP_SCAN, OP_STEAL, OP_OFF, OP_ALLOFF, OP_TICK, OP_MISC
	} op_t;

	function automatic logic [16:0] semitone(input logic [3:0] k);
		logic [16:0] v;
		case (k)
			4'd0:    v = 17'd65536;
			4'd1:    v = 17'd69433;
			4'd2:    v = 17'd73562;
			4'd3:    v = 17'd77936;
			4'd4:    v = 17'd82570;
			4'd5:    v = 17'd87480;
			4'd6:    v = 17'd92682;
			4'd7:    v = 17'd98193;
			4'd8:    v = 17'd104032;
			4'd9:    v = 17'd110218;
			4'd10:   v = 17'd116772;
			4'd11:   v = 17'd123715;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

endpackage

[rtl/pva_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pva_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                      wdata,
	input  logic                              re,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                      rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/polyphonic_voice_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator
// Sampler voice table with oldest-voice stealing, release fades and per-frame
// position and amplitude reporting.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on in_valid/in_ready, one beat each; results leave on
// out_valid/out_ready. Configuration registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is
// idle; the block itself does not enforce this. Voice state lives in one RAM
// of NUM_VOICES entries; every command except reset sweeps it one voice per
// cycle through a read, update and write-back pipeline. Note-on, note-off and
// all-off give one result beat; a note-on with every voice busy sweeps twice
// (oldest-voice search, then the steal). A frame tick fills a result buffer,
// then gives min(NUM_VOICES, 16) beats one per cycle while the receiver is
// ready. Reset and unused codes give their beat without a sweep.
// The output register lets the next command in while a single result waits;
// during a tick's beats a stalled receiver holds the block.
// arst_n clears voice flags, age counter and registers to their reset values;
// voice data is written on voice start before it is ever used.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pva_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output pva_pkg::out_t  out_data,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [23:0]    cfg_data
);

	localparam logic [pva_pkg::VW-1:0] LAST_V = pva_pkg::VW'(pva_pkg::NUM_VOICES - 1);
	localparam logic [pva_pkg::KW-1:0] LAST_K = pva_pkg::KW'(pva_pkg::NRES - 1);

	// configuration
	logic [16:0] release_step_q, steal_step_q;
	logic [23:0] device_ratio_q, sample_frames_q, clip_start_q, clip_length_q, clip_rate_q;
	logic [1:0]  clip_mode_q;
	logic [23:0] clip_len_q, remaining;
	logic [47:0] clip_prod_q;

	// control
	pva_pkg::st_t state_q, state_d;
	pva_pkg::op_t op_q;
	logic [pva_pkg::VW-1:0] idx_q, chosen_q, first_free;
	logic                   any_free, stolen_q;
	logic [6:0]             key_q;
	logic [15:0]            vel_q;
	logic [31:0]            min_q, age_q;
	logic [pva_pkg::KW-1:0] k_q;
	logic                   have_q;
	logic                   in_fire, out_free, rd_en, res_re, load_resp, load_emit, drained;

	// voice flags
	logic [pva_pkg::NUM_VOICES-1:0] act_q, rel_q, pend_q;
	logic [6:0] act_cnt;

	// stage 1
	logic                   s1_v_q;
	logic [pva_pkg::VW-1:0] s1_slot_q;
	logic [pva_pkg::ENT_W-1:0] ram_rdata;
	pva_pkg::voice_ent_t    e, nx;
	logic                   a, r, p, we1, fwe1, na, nr, np, bg, snd;
	logic [6:0]             bkey;
	logic [15:0]            bgain;
	logic [39:0]            lim;
	logic [40:0]            psum;
	logic [7:0]             dkey;
	logic [15:0]            qmul;
	logic [4:0]             oct;
	logic [7:0]             rem12;
	logic [40:0]            rprod;
	logic [32:0]            ampprod;

	// stage 2
	logic                   s2_v_q, s2_we_q, s2_fwe_q, s2_na_q, s2_nr_q, s2_np_q;
	logic                   s2_bg_q, s2_snd_q;
	logic [pva_pkg::VW-1:0] s2_slot_q;
	pva_pkg::voice_ent_t    s2_ent_q, wr_ent;
	logic [40:0]            s2_rprod_q, rate_full;
	logic [4:0]             s2_shift_q;
	logic [32:0]            s2_amp_q;
	logic [39:0]            s2_pos_q;
	logic [23:0]            begin_rate;
	logic                   res_we;
	pva_pkg::res_ent_t      res_w, res_r;
	logic [pva_pkg::RES_W-1:0] res_rdata;
	logic [pva_pkg::KW-1:0] res_raddr;

	pva_pkg::out_t out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_step_q  <= 17'd341;
			steal_step_q    <= 17'd683;
			device_ratio_q  <= 24'd65536;
			sample_frames_q <= 24'd0;
			clip_mode_q     <= 2'd0;
			clip_start_q    <= 24'd0;
			clip_length_q   <= 24'd0;
			clip_rate_q     <= 24'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				pva_pkg::REG_RELEASE_STEP:  release_step_q  <= cfg_data[16:0];
				pva_pkg::REG_STEAL_STEP:    steal_step_q    <= cfg_data[16:0];
				pva_pkg::REG_DEVICE_RATIO:  device_ratio_q  <= cfg_data;
				pva_pkg::REG_SAMPLE_FRAMES: sample_frames_q <= cfg_data;
				pva_pkg::REG_CLIP_MODE:     clip_mode_q     <= cfg_data[1:0];
				pva_pkg::REG_CLIP_START:    clip_start_q    <= cfg_data;
				pva_pkg::REG_CLIP_LENGTH:   clip_length_q   <= cfg_data;
				pva_pkg::REG_CLIP_RATE:     clip_rate_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign remaining = (sample_frames_q > clip_start_q) ? (sample_frames_q - clip_start_q) : 24'd0;

	always_ff @(posedge clk) begin
		clip_len_q  <= (clip_length_q != 24'd0 && clip_length_q < remaining) ?
			clip_length_q : remaining;
		clip_prod_q <= clip_rate_q * device_ratio_q;
	end

	// free voice search
	always_comb begin
		any_free   = 1'b0;
		first_free = '0;
		for (int i = pva_pkg::NUM_VOICES - 1; i >= 0; i--) begin
			if (!act_q[i]) begin
				any_free   = 1'b1;
				first_free = pva_pkg::VW'(i);
			end
		end
	end

	assign act_cnt  = 7'($countones(act_q));
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign drained  = !s1_v_q && !s2_v_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pva_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (in_data.func inside {pva_pkg::FN_NOTE_ON, pva_pkg::FN_NOTE_OFF,
						pva_pkg::FN_ALL_OFF, pva_pkg::FN_TICK}) begin
						state_d = pva_pkg::ST_SWEEP;
					end else begin
						state_d = pva_pkg::ST_RESP;
					end
				end
			end
			pva_pkg::ST_SWEEP: begin
				if (idx_q == LAST_V) state_d = pva_pkg::ST_DRAIN;
			end
			pva_pkg::ST_DRAIN: begin
				if (drained) begin
					if (op_q == pva_pkg::OP_SCAN)      state_d = pva_pkg::ST_SWEEP;
					else if (op_q == pva_pkg::OP_TICK) state_d = pva_pkg::ST_EMIT;
					else                               state_d = pva_pkg::ST_RESP;
				end
			end
			pva_pkg::ST_RESP: begin
				if (out_free) state_d = pva_pkg::ST_IDLE;
			end
			pva_pkg::ST_EMIT: begin
				if (have_q && out_free && k_q == LAST_K) state_d = pva_pkg::ST_IDLE;
			end
			default: state_d = pva_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		res_re    = 1'b0;
		load_resp = 1'b0;
		load_emit = 1'b0;
		res_raddr = k_q;
		case (state_q)
			pva_pkg::ST_IDLE:  in_ready = 1'b1;
			pva_pkg::ST_SWEEP: rd_en = 1'b1;
			pva_pkg::ST_RESP:  load_resp = out_free;
			pva_pkg::ST_EMIT: begin
				if (!have_q) begin
					res_re = 1'b1;
				end else if (out_free) begin
					load_emit = 1'b1;
					res_re    = (k_q != LAST_K);
					res_raddr = k_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pva_pkg::ST_IDLE;
			op_q     <= pva_pkg::OP_MISC;
			idx_q    <= '0;
			chosen_q <= '0;
			stolen_q <= 1'b0;
			k_q      <= '0;
			have_q   <= 1'b0;
			s1_v_q   <= 1'b0;
			s2_v_q   <= 1'b0;
			act_q    <= '0;
			rel_q    <= '0;
			pend_q   <= '0;
			age_q    <= '0;
		end else begin
			state_q <= state_d;
			s1_v_q  <= rd_en;
			s2_v_q  <= s1_v_q;
			if (rd_en) idx_q <= (idx_q == LAST_V) ? '0 : idx_q + 1'b1;
			if (in_fire) begin
				idx_q    <= '0;
				k_q      <= '0;
				have_q   <= 1'b0;
				chosen_q <= '0;
				stolen_q <= 1'b0;
				case (in_data.func)
					pva_pkg::FN_NOTE_ON: begin
						op_q     <= any_free ? pva_pkg::OP_ON : pva_pkg::OP_SCAN;
						chosen_q <= any_free ? first_free : '0;
						stolen_q <= !any_free;
					end
					pva_pkg::FN_NOTE_OFF: op_q <= pva_pkg::OP_OFF;
					pva_pkg::FN_ALL_OFF:  op_q <= pva_pkg::OP_ALLOFF;
					pva_pkg::FN_TICK:     op_q <= pva_pkg::OP_TICK;
					pva_pkg::FN_RESET: begin
						op_q   <= pva_pkg::OP_MISC;
						act_q  <= '0;
						rel_q  <= '0;
						pend_q <= '0;
					end
					default: op_q <= pva_pkg::OP_MISC;
				endcase
			end
			if (state_q == pva_pkg::ST_DRAIN && drained && op_q == pva_pkg::OP_SCAN) begin
				op_q <= pva_pkg::OP_STEAL;
			end
			// oldest voice: strict compare keeps the lowest slot on ties
			if (s1_v_q && op_q == pva_pkg::OP_SCAN &&
				(s1_slot_q == '0 || e.age < min_q)) begin
				chosen_q <= s1_slot_q;
			end
			if (s2_v_q && s2_fwe_q) begin
				act_q[s2_slot_q]  <= s2_na_q;
				rel_q[s2_slot_q]  <= s2_nr_q;
				pend_q[s2_slot_q] <= s2_np_q;
			end
			if (s2_v_q && s2_we_q && s2_bg_q) age_q <= age_q + 32'd1;
			if (res_re && !have_q) have_q <= 1'b1;
			if (load_emit) begin
				k_q <= k_q + 1'b1;
				if (k_q == LAST_K) have_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		s1_slot_q <= idx_q;
		if (s1_v_q && op_q == pva_pkg::OP_SCAN && (s1_slot_q == '0 || e.age < min_q)) begin
			min_q <= e.age;
		end
		if (in_fire) begin
			key_q <= in_data.note;
			vel_q <= in_data.velocity;
		end
	end

	pva_ram #(.W(pva_pkg::ENT_W), .D(pva_pkg::NUM_VOICES)) u_voice_ram (
		.clk   (clk),
		.we    (s2_v_q && s2_we_q),
		.waddr (s2_slot_q),
		.wdata (wr_ent),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// stage 1: update one voice
	always_comb begin
		e     = pva_pkg::voice_ent_t'(ram_rdata);
		a     = act_q[s1_slot_q];
		r     = rel_q[s1_slot_q];
		p     = pend_q[s1_slot_q];
		nx    = e;
		we1   = 1'b0;
		fwe1  = 1'b0;
		na    = a;
		nr    = r;
		np    = p;
		bg    = 1'b0;
		snd   = 1'b0;
		bkey  = (op_q == pva_pkg::OP_ON) ? key_q : e.pkey;
		bgain = (op_q == pva_pkg::OP_ON) ? vel_q : e.pgain;
		lim   = {e.len - 24'd1, 16'd0};
		psum  = {1'b0, e.pos} + {17'd0, e.rate};
		case (op_q)
			pva_pkg::OP_ON: begin
				if (s1_slot_q == chosen_q) begin
					bg   = 1'b1;
					fwe1 = 1'b1;
				end
			end
			pva_pkg::OP_STEAL: begin
				if (s1_slot_q == chosen_q) begin
					we1      = 1'b1;
					fwe1     = 1'b1;
					nx.fstep = steal_step_q;
					nx.pkey  = key_q;
					nx.pgain = vel_q;
					nr       = 1'b1;
					np       = 1'b1;
				end
			end
			pva_pkg::OP_OFF, pva_pkg::OP_ALLOFF: begin
				if (a && !r && (op_q == pva_pkg::OP_ALLOFF || e.key == key_q)) begin
					we1      = 1'b1;
					fwe1     = 1'b1;
					nx.fstep = release_step_q;
					nr       = 1'b1;
					if (op_q == pva_pkg::OP_ALLOFF) np = 1'b0;
				end
			end
			pva_pkg::OP_TICK: begin
				if (a) begin
					if (e.len < 24'd2 || e.pos >= lim) begin
						fwe1 = 1'b1;
						na   = 1'b0;
						np   = 1'b0;
					end else begin
						snd    = 1'b1;
						we1    = 1'b1;
						nx.pos = psum[40] ? pva_pkg::POS_MAX : psum[39:0];
						if (r) begin
							if (e.fade > e.fstep) begin
								nx.fade = e.fade - e.fstep;
							end else begin
								nx.fade = '0;
								fwe1    = 1'b1;
								na      = 1'b0;
								bg      = p;
							end
						end
					end
				end
			end
			default: ;
		endcase
		if (bg) begin
			we1      = 1'b1;
			na       = 1'b1;
			nr       = 1'b0;
			np       = 1'b0;
			nx.key   = bkey;
			nx.gain  = bgain;
			nx.pos   = '0;
			nx.fade  = pva_pkg::FADE_ONE;
			nx.fstep = '0;
			nx.len   = clip_mode_q[0] ? clip_len_q : sample_frames_q;
		end
	end

	// semitone and octave of the key, divide by twelve via reciprocal
	assign dkey    = {1'b0, bkey} + 8'(pva_pkg::KEY_BIAS);
	assign qmul    = 16'(dkey) * 16'd171;
	assign oct     = qmul[15:11];
	assign rem12   = dkey - 8'(oct) * 8'd12;
	assign rprod   = pva_pkg::semitone(rem12[3:0]) * device_ratio_q;
	assign ampprod = e.gain * e.fade;

	always_ff @(posedge clk) begin
		s2_slot_q  <= s1_slot_q;
		s2_we_q    <= s1_v_q && we1;
		s2_fwe_q   <= s1_v_q && fwe1;
		s2_na_q    <= na;
		s2_nr_q    <= nr;
		s2_np_q    <= np;
		s2_bg_q    <= bg;
		s2_snd_q   <= snd;
		s2_ent_q   <= nx;
		s2_rprod_q <= rprod;
		s2_shift_q <= 5'd27 - oct;
		s2_amp_q   <= ampprod;
		s2_pos_q   <= e.pos;
	end

	// stage 2: finish the start rate, write back
	assign rate_full = s2_rprod_q >> s2_shift_q;

	always_comb begin
		if (clip_mode_q[0]) begin
			begin_rate = (|clip_prod_q[47:40]) ? pva_pkg::RATE_MAX : clip_prod_q[39:16];
		end else begin
			begin_rate = (|rate_full[40:24]) ? pva_pkg::RATE_MAX : rate_full[23:0];
		end
		wr_ent = s2_ent_q;
		if (s2_bg_q) begin
			wr_ent.rate = begin_rate;
			wr_ent.age  = age_q + 32'd1;
		end
	end

	assign res_we    = s2_v_q && op_q == pva_pkg::OP_TICK &&
		(32'(s2_slot_q) < pva_pkg::NRES);
	assign res_w.snd = s2_snd_q;
	assign res_w.pos = s2_snd_q ? s2_pos_q : '0;
	assign res_w.amp = s2_snd_q ? s2_amp_q[32:16] : '0;

	pva_ram #(.W(pva_pkg::RES_W), .D(pva_pkg::NRES)) u_result_ram (
		.clk   (clk),
		.we    (res_we),
		.waddr (pva_pkg::KW'(s2_slot_q)),
		.wdata (res_w),
		.re    (res_re),
		.raddr (res_raddr),
		.rdata (res_rdata)
	);

	assign res_r = pva_pkg::res_ent_t'(res_rdata);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_resp || load_emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_resp) begin
			out_q.slot          <= 6'(chosen_q);
			out_q.sounding      <= 1'b0;
			out_q.read_position <= '0;
			out_q.amplitude     <= '0;
			out_q.stolen        <= stolen_q;
			out_q.active_count  <= act_cnt;
			out_q.last          <= 1'b1;
		end else if (load_emit) begin
			out_q.slot          <= 6'(k_q);
			out_q.sounding      <= res_r.snd;
			out_q.read_position <= res_r.pos;
			out_q.amplitude     <= res_r.amp;
			out_q.stolen        <= 1'b0;
			out_q.active_count  <= act_cnt;
			out_q.last          <= (k_q == LAST_K);
		end
	end

	assign out_data = out_q;

	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_v_q && s2_we_q && rd_en) |-> (s2_slot_q != idx_q))
		else $error("voice write back collides with a read of the same slot");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pva_pkg::ST_IDLE) |-> (!s1_v_q && !s2_v_q))
		else $error("update pipeline busy while idle");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.active_count <= 7'(pva_pkg::NUM_VOICES)))
		else $error("active count beyond voice count");

endmodule
